// File: sv/i2crtm_pkg.sv
// ----------------------------------------------------------------------------
// i2crtm_pkg
// shared types, codes and segment tables of the i2c register transaction master
// ----------------------------------------------------------------------------
package i2crtm_pkg;

    // command codes on the op field
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // register indexes on the configuration port
    localparam logic REG_DEVICE_ADDRESS = 1'b0;
    localparam logic REG_ACK_TIMEOUT    = 1'b1;

    localparam logic [7:0] ACK_LIMIT_RESET = 8'd100;
    localparam logic [8:0] TCOUNT_MAX      = 9'd511;
    localparam logic [3:0] SUB_LAST        = 4'd15;
    localparam logic [3:0] WRITE_LEN       = 4'd10;
    localparam logic [3:0] READ_LEN        = 4'd13;

    typedef enum logic [3:0] {
        SEG_START    = 4'd0,
        SEG_SEND_AW  = 4'd1,
        SEG_SEND_AR  = 4'd2,
        SEG_SEND_REG = 4'd3,
        SEG_SEND_MSB = 4'd4,
        SEG_SEND_LSB = 4'd5,
        SEG_ACK      = 4'd6,
        SEG_READ     = 4'd7,
        SEG_MACK     = 4'd8,
        SEG_MNACK    = 4'd9,
        SEG_STOP     = 4'd10
    } t_seg;

    typedef struct packed {
        logic [6:0] device_address;
        logic [7:0] ack_timeout_limit;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  reg_addr;
        logic [15:0] write_value;
        logic        sda_in;
    } t_item;

    typedef struct packed {
        logic        scl;
        logic        sda_out;
        logic        busy_res;
        logic        done_res;
        logic        ack_error;
        logic [15:0] read_data;
    } t_result;

    // segment running at a given phase of a write or read transaction
    function automatic t_seg seg_at(input logic is_read, input logic [3:0] phase);
        t_seg seg;
        seg = SEG_STOP;
        if (is_read) begin
            unique case (phase)
                4'd0:    seg = SEG_START;
                4'd1:    seg = SEG_SEND_AW;
                4'd2:    seg = SEG_ACK;
                4'd3:    seg = SEG_SEND_REG;
                4'd4:    seg = SEG_ACK;
                4'd5:    seg = SEG_START;
                4'd6:    seg = SEG_SEND_AR;
                4'd7:    seg = SEG_ACK;
                4'd8:    seg = SEG_READ;
                4'd9:    seg = SEG_MACK;
                4'd10:   seg = SEG_READ;
                4'd11:   seg = SEG_MNACK;
                default: seg = SEG_STOP;
            endcase
        end else begin
            unique case (phase)
                4'd0:    seg = SEG_START;
                4'd1:    seg = SEG_SEND_AW;
                4'd2:    seg = SEG_ACK;
                4'd3:    seg = SEG_SEND_REG;
                4'd4:    seg = SEG_ACK;
                4'd5:    seg = SEG_SEND_MSB;
                4'd6:    seg = SEG_ACK;
                4'd7:    seg = SEG_SEND_LSB;
                4'd8:    seg = SEG_ACK;
                default: seg = SEG_STOP;
            endcase
        end
        return seg;
    endfunction

endpackage

// File: sv/i2crtm_core.sv
// ----------------------------------------------------------------------------
// i2crtm_core
// transaction sequencer: advances one half-bit tick per step, result is combinational
// ----------------------------------------------------------------------------
module i2crtm_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  i2crtm_pkg::t_cfg  i_cfg,
    input  i2crtm_pkg::t_item i_item,
    output i2crtm_pkg::t_result o_res
);
    import i2crtm_pkg::*;

    logic        r_active, n_active;
    logic        r_is_read, n_is_read;
    logic [3:0]  r_phase, n_phase;
    logic [3:0]  r_sub, n_sub;
    logic [8:0]  r_tcount, n_tcount;
    logic [7:0]  r_shreg, n_shreg;
    logic [15:0] r_rdata, n_rdata;
    logic        r_err, n_err;
    logic [7:0]  r_lat_reg, n_lat_reg;
    logic [15:0] r_lat_val, n_lat_val;

    logic        start;
    logic        e_is_read;
    logic [3:0]  e_phase, e_sub;
    logic [8:0]  e_tcount, tcount_inc;
    logic [7:0]  e_shreg, shreg_new, tx_byte;
    logic [15:0] e_rdata, e_lat_val;
    logic [7:0]  e_lat_reg;
    logic        e_err;
    logic [3:0]  last_phase;
    t_seg        seg;

    assign start = !r_active && (i_item.op == OP_READ || i_item.op == OP_WRITE);

    // a starting command sees a freshly cleared transaction context
    assign e_is_read = start ? (i_item.op == OP_READ) : r_is_read;
    assign e_phase   = start ? 4'd0 : r_phase;
    assign e_sub     = start ? 4'd0 : r_sub;
    assign e_tcount  = start ? 9'd0 : r_tcount;
    assign e_shreg   = start ? 8'd0 : r_shreg;
    assign e_rdata   = start ? 16'd0 : r_rdata;
    assign e_err     = start ? 1'b0 : r_err;
    assign e_lat_reg = start ? i_item.reg_addr : r_lat_reg;
    assign e_lat_val = start ? i_item.write_value : r_lat_val;

    assign seg        = seg_at(e_is_read, e_phase);
    assign last_phase = (e_is_read ? READ_LEN : WRITE_LEN) - 4'd1;
    assign tcount_inc = (e_tcount < TCOUNT_MAX) ? e_tcount + 9'd1 : e_tcount;
    assign shreg_new  = e_sub[0] ? {e_shreg[6:0], i_item.sda_in} : e_shreg;

    always_comb begin
        unique case (seg)
            SEG_SEND_AW:  tx_byte = {i_cfg.device_address, 1'b0};
            SEG_SEND_AR:  tx_byte = {i_cfg.device_address, 1'b1};
            SEG_SEND_REG: tx_byte = e_lat_reg;
            SEG_SEND_MSB: tx_byte = e_lat_val[15:8];
            default:      tx_byte = e_lat_val[7:0];
        endcase
    end

    always_comb begin
        n_active  = r_active;
        n_is_read = e_is_read;
        n_phase   = e_phase;
        n_sub     = e_sub;
        n_tcount  = e_tcount;
        n_shreg   = e_shreg;
        n_rdata   = e_rdata;
        n_err     = e_err;
        n_lat_reg = e_lat_reg;
        n_lat_val = e_lat_val;

        o_res = '{scl: 1'b1, sda_out: 1'b1, busy_res: 1'b0, done_res: 1'b0,
                  ack_error: 1'b0, read_data: 16'd0};

        if (r_active || start) begin
            n_active       = 1'b1;
            o_res.busy_res = 1'b1;
            unique case (seg) inside
                SEG_START: begin
                    o_res.scl     = (e_sub != 4'd0);
                    o_res.sda_out = (e_sub < 4'd2);
                    if (e_sub >= 4'd2) begin
                        n_phase  = e_phase + 4'd1;
                        n_sub    = 4'd0;
                        n_tcount = 9'd0;
                    end else begin
                        n_sub = e_sub + 4'd1;
                    end
                end
                SEG_ACK: begin
                    if (e_sub == 4'd0) begin
                        o_res.scl = 1'b0;
                        n_sub     = 4'd1;
                    end else if (!i_item.sda_in) begin
                        n_phase  = e_phase + 4'd1;
                        n_sub    = 4'd0;
                        n_tcount = 9'd0;
                    end else if (tcount_inc > {1'b0, i_cfg.ack_timeout_limit}) begin
                        // no acknowledge in time: jump straight to stop
                        n_err    = 1'b1;
                        n_phase  = last_phase;
                        n_sub    = 4'd0;
                        n_tcount = 9'd0;
                    end else begin
                        n_tcount = tcount_inc;
                    end
                end
                SEG_READ: begin
                    o_res.scl = e_sub[0];
                    n_shreg   = shreg_new;
                    if (e_sub == SUB_LAST) begin
                        n_rdata  = {e_rdata[7:0], shreg_new};
                        n_shreg  = 8'd0;
                        n_phase  = e_phase + 4'd1;
                        n_sub    = 4'd0;
                        n_tcount = 9'd0;
                    end else begin
                        n_sub = e_sub + 4'd1;
                    end
                end
                SEG_MACK, SEG_MNACK: begin
                    o_res.scl     = e_sub[0];
                    o_res.sda_out = (seg == SEG_MNACK);
                    if (e_sub >= 4'd1) begin
                        n_phase  = e_phase + 4'd1;
                        n_sub    = 4'd0;
                        n_tcount = 9'd0;
                    end else begin
                        n_sub = e_sub + 4'd1;
                    end
                end
                SEG_STOP: begin
                    o_res.scl     = (e_sub != 4'd0);
                    o_res.sda_out = (e_sub >= 4'd2);
                    if (e_sub >= 4'd2) begin
                        o_res.done_res  = 1'b1;
                        o_res.ack_error = e_err;
                        o_res.read_data = (e_is_read && !e_err) ? e_rdata : 16'd0;
                        n_active = 1'b0;
                        n_phase  = 4'd0;
                        n_sub    = 4'd0;
                        n_tcount = 9'd0;
                    end else begin
                        n_sub = e_sub + 4'd1;
                    end
                end
                default: begin
                    // address, register and data bytes, msb first
                    o_res.scl     = e_sub[0];
                    o_res.sda_out = tx_byte[3'd7 - e_sub[3:1]];
                    if (e_sub == SUB_LAST) begin
                        n_phase  = e_phase + 4'd1;
                        n_sub    = 4'd0;
                        n_tcount = 9'd0;
                    end else begin
                        n_sub = e_sub + 4'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= 1'b0;
            r_is_read <= 1'b0;
            r_phase   <= 4'd0;
            r_sub     <= 4'd0;
            r_tcount  <= 9'd0;
            r_shreg   <= 8'd0;
            r_rdata   <= 16'd0;
            r_err     <= 1'b0;
            r_lat_reg <= 8'd0;
            r_lat_val <= 16'd0;
        end else if (i_step) begin
            r_active  <= n_active;
            r_is_read <= n_is_read;
            r_phase   <= n_phase;
            r_sub     <= n_sub;
            r_tcount  <= n_tcount;
            r_shreg   <= n_shreg;
            r_rdata   <= n_rdata;
            r_err     <= n_err;
            r_lat_reg <= n_lat_reg;
            r_lat_val <= n_lat_val;
        end
    end

    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active && !r_is_read |-> r_phase < WRITE_LEN)
        else $error("write phase out of range");

    a_read_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active && r_is_read |-> r_phase < READ_LEN)
        else $error("read phase out of range");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_active |-> r_phase == 4'd0 && r_sub == 4'd0 && r_tcount == 9'd0)
        else $error("sequencer left state behind when going idle");

endmodule

// File: sv/i2c_register_transaction_master_unit.sv
// ----------------------------------------------------------------------------
// i2c_register_transaction_master_unit
// i2c master running one 16-bit register read or write per command
// ----------------------------------------------------------------------------
// Every input word is one half-bit tick of the i2c bus and produces exactly one
// result word with the scl and sda levels to drive for that tick. An op of read
// or write arriving while idle starts a transaction on that very tick: start,
// address+w, register, then either msb and lsb for a write, or a repeated start,
// address+r and two read bytes (ack after the first, nack after the second),
// then stop. Ops arriving while busy are ignored. During an acknowledge the
// master counts high sda samples while scl is high; once the count passes
// ack_timeout_limit it aborts with a stop and flags ack_error on the done word.
// Timing: one input word per clock while o_in_stall is low. The sequencer state
// is updated and the result word registered in the same edge that accepts the
// input, so a result appears in the cycle after; the output register decouples
// the two channels and a new word is taken whenever that register is empty or
// being drained. Configuration registers sit on an apb port (device address at
// 0x0, timeout limit at 0x4) and should be written while the unit is idle.
// ----------------------------------------------------------------------------
module i2c_register_transaction_master_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // apb configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // tick input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_reg_addr,
    input  logic [15:0] i_write_value,
    input  logic        i_sda_in,

    // result output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_scl,
    output logic        o_sda_out,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic        o_ack_error,
    output logic [15:0] o_read_data
);
    import i2crtm_pkg::*;

    // configuration registers
    logic [6:0] r_device_address;
    logic [7:0] r_ack_timeout_limit;
    logic       cfg_write;
    t_cfg       cfg;

    // handshake and output register
    logic       in_accept;
    logic       r_out_valid, n_out_valid;
    t_item      item;
    t_result    res;
    t_result    r_res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_device_address    <= 7'd0;
            r_ack_timeout_limit <= ACK_LIMIT_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_DEVICE_ADDRESS: r_device_address    <= pwdata[6:0];
                REG_ACK_TIMEOUT:    r_ack_timeout_limit <= pwdata[7:0];
                default:            r_device_address    <= r_device_address;
            endcase
        end
    end

    // register readback, low address bits are the byte offset
    always_comb begin
        unique case (paddr[2])
            REG_DEVICE_ADDRESS: prdata = {25'd0, r_device_address};
            REG_ACK_TIMEOUT:    prdata = {24'd0, r_ack_timeout_limit};
            default:            prdata = 32'd0;
        endcase
    end

    assign cfg = '{device_address: r_device_address,
                   ack_timeout_limit: r_ack_timeout_limit};

    assign item = '{op: i_op, reg_addr: i_reg_addr,
                    write_value: i_write_value, sda_in: i_sda_in};

    // hold off only while a result waits and the consumer is stalling
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    i2crtm_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_accept),
        .i_cfg   (cfg),
        .i_item  (item),
        .o_res   (res)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (in_accept) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, loaded with each accepted tick
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_res <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl       = r_res.scl;
    assign o_sda_out   = r_res.sda_out;
    assign o_busy_res  = r_res.busy_res;
    assign o_done_res  = r_res.done_res;
    assign o_ack_error = r_res.ack_error;
    assign o_read_data = r_res.read_data;

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted tick produced no result word");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_res.done_res || r_res.ack_error) |-> r_res.busy_res)
        else $error("done or error flagged outside a transaction");

    a_data_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_res.read_data != 16'd0 || r_res.ack_error)
            |-> r_res.done_res)
        else $error("read data or error shown without done");

endmodule
